/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/sil_pkg.sv */
// Types and codes shared by the sorted integer list modules.
`timescale 1ns / 1ps
package sil_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                ins;
        logic                del;
        t_value              value;
        logic [POS_W-1:0]    position;
    } t_cell_ctl;

endpackage

/* rtl/sil_cell.sv */
// One cell of the sorted list: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
module sil_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sil_pkg::t_cell_ctl i_ctl,
    input  sil_pkg::t_value    i_left_value,
    input  logic               i_left_valid,
    input  logic               i_left_lt,
    input  sil_pkg::t_value    i_right_value,
    input  logic               i_right_valid,
    output sil_pkg::t_value    o_value,
    output logic               o_valid,
    output logic               o_lt,
    output logic               o_boundary,
    output sil_pkg::t_value    o_hit_value
);
    import sil_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   r_valid;
    logic   n_valid;
    logic   pos_hit;
    logic   pos_at_or_below;

    assign o_lt            = r_valid && (r_value < i_ctl.value);
    assign o_boundary      = !o_lt && i_left_lt;
    assign pos_hit         = (32'(i_ctl.position) == IDX);
    assign pos_at_or_below = (32'(i_ctl.position) <= IDX);
    assign o_hit_value     = pos_hit ? r_value : '0;
    assign o_value         = r_value;
    assign o_valid         = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.ins && !o_lt) begin
            n_value = i_left_lt ? i_ctl.value : i_left_value;
            n_valid = i_left_valid;
        end else if (i_ctl.del && pos_at_or_below) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

/* rtl/sorted_integer_list.sv */
// Sorted integer list: a chain of cells kept in ascending order.
//
// Input words (slave side): tuser carries the request kind, insert or delete;
// tdata carries the value to insert and the position to delete.
// Output words (master side): one per input word, with status, position,
// value inserted or removed, and the entry count after the operation.
//
// Every cell compares its entry with the broadcast value and decides locally
// whether to keep it, take the new value or take a neighbor's entry, so an
// insert or delete completes in the accept cycle. The result is registered in
// the output register when the input word is accepted; one word is
// taken per cycle as long as the receiver keeps tready high.
// If the receiver stalls, the result holds and one more input word is taken
// only when the output register frees in the same cycle.
// Reset empties the list at once (valid bits per cell) and drops any
// pending result; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
module sorted_integer_list #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // value[31:0], position[37:32], zero pad
    input  logic        i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // status[1:0], where[7:2], item_value[39:8],
                                     // count[46:40], zero pad
);
    import sil_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int WW = (IW > POS_W) ? IW : POS_W;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    logic [47:0]      r_out_data;
    logic [47:0]      n_out_data;

    t_cell_ctl        ctl;
    logic             accept;
    logic             is_insert;
    logic             full;
    logic             bad_pos;
    t_value           in_value;
    logic [POS_W-1:0] in_pos;

    t_value           c_value [DEPTH];
    logic             c_valid [DEPTH];
    logic             c_lt    [DEPTH];
    logic             c_bound [DEPTH];
    t_value           c_hit   [DEPTH];

    logic [IW-1:0]    ins_idx;
    t_value           removed;
    logic [WW-1:0]    ins_idx_x;
    logic [XW-1:0]    count_x;

    logic [STATUS_W-1:0] res_status;
    logic [POS_W-1:0]    res_where;
    t_value              res_value;

    assign in_value  = i_s_tdata[VALUE_W-1:0];
    assign in_pos    = i_s_tdata[VALUE_W +: POS_W];
    assign is_insert = (i_s_tuser == REQ_INSERT);
    assign accept    = i_s_tvalid && o_s_tready;
    assign full      = (r_count == CW'(DEPTH));
    assign bad_pos   = (PW'(in_pos) >= PW'(r_count));

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign ctl.ins      = accept && is_insert && !full;
    assign ctl.del      = accept && !is_insert && !bad_pos;
    assign ctl.value    = in_value;
    assign ctl.position = in_pos;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_value left_value;
        logic   left_valid;
        logic   left_lt;
        t_value right_value;
        logic   right_valid;

        if (i == 0) begin : g_first
            assign left_value = in_value;
            assign left_valid = 1'b1;
            assign left_lt    = 1'b1;
        end else begin : g_mid
            assign left_value = c_value[i-1];
            assign left_valid = c_valid[i-1];
            assign left_lt    = c_lt[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_value = c_value[i];
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_value = c_value[i+1];
            assign right_valid = c_valid[i+1];
        end

        sil_cell #(
            .IDX(i)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_left_value  (left_value),
            .i_left_valid  (left_valid),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .i_right_valid (right_valid),
            .o_value       (c_value[i]),
            .o_valid       (c_valid[i]),
            .o_lt          (c_lt[i]),
            .o_boundary    (c_bound[i]),
            .o_hit_value   (c_hit[i])
        );
    end

    // Boundary is one-hot when the list is not full; hit is one-hot or none.
    always_comb begin
        ins_idx = '0;
        removed = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (c_bound[i]) begin
                ins_idx = ins_idx | IW'(i);
            end
            removed = removed | c_hit[i];
        end
    end

    assign ins_idx_x = WW'(ins_idx);

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (ctl.del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign count_x = XW'(n_count);

    always_comb begin
        res_status = ST_OK;
        res_where  = in_pos;
        res_value  = removed;
        if (is_insert) begin
            res_value = in_value;
            if (full) begin
                res_status = ST_FULL;
                res_where  = '0;
            end else begin
                res_where  = ins_idx_x[POS_W-1:0];
            end
        end else if (bad_pos) begin
            res_status = ST_BADPOS;
            res_value  = '0;
        end
        n_out_data = {1'b0, count_x[COUNT_W-1:0], res_value, res_where, res_status};
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/sil_checker.sv */
// Port-level checks for the sorted integer list, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sil_checker #(
    parameter int DEPTH = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);
    import sil_pkg::*;

    logic in_word;
    logic in_insert;
    logic out_stall;
    logic out_full;
    logic [VALUE_W-1:0] in_value;
    logic [COUNT_W-1:0] depth_code;

    assign in_word    = i_s_tvalid && o_s_tready;
    assign in_insert  = in_word && (i_s_tuser == REQ_INSERT);
    assign in_value   = i_s_tdata[VALUE_W-1:0];
    assign out_stall  = o_m_tvalid && !i_m_tready;
    assign out_full   = o_m_tvalid && (o_m_tdata[1:0] == ST_FULL);
    assign depth_code = COUNT_W'(DEPTH);

    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_word, o_m_tvalid)
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(o_m_tdata))
    `ASSERT_NEXT(a_insert_echo, i_clk, i_rst_n, in_insert, o_m_tdata[39:8] == $past(in_value))
    `ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[1:0] <= ST_BADPOS)
    `ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, out_full, o_m_tdata[46:40] == depth_code)

endmodule

bind sorted_integer_list sil_checker #(.DEPTH(DEPTH)) u_sil_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

/* bench/testbench.sv */
// Self-checking testbench for the sorted integer list: stream stimulus, list predictor, checker.
`timescale 1ns / 1ps
module testbench;
    import sil_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 260;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    where;
        t_value              item_value;
        logic [COUNT_W-1:0]  count;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;   // value[31:0], position[37:32], zero pad
    logic        i_s_tuser = 1'b0; // req_type
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // status[1:0], where[7:2], item_value[39:8],
                                   // count[46:40], zero pad

    t_value  stored_q[$];
    t_result expected_q[$];
    t_result exp_r;
    bit      quiet = 1'b0;
    bit      hold_request = 1'b0;
    bit      hold_seen = 1'b0;
    int      hold_left = 0;
    int      idle_cycles = 0;
    int      errors = 0;
    int      n_words = 0;
    int      n_ins_ok = 0;
    int      n_del_ok = 0;
    int      n_full = 0;
    int      n_badpos = 0;
    int      n_checked = 0;
    int      peak_count = 0;

    sorted_integer_list #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the local copy of the list and returns its result word.
    function automatic t_result apply_request(logic op, t_value v, logic [POS_W-1:0] pos);
        t_result r;
        int      j;
        int      n;
        n = stored_q.size();
        n_words++;
        if (op == REQ_INSERT) begin
            if (n >= LIST_DEPTH) begin
                r = '{ST_FULL, '0, v, COUNT_W'(n)};
                n_full++;
            end else begin
                j = 0;
                while (j < n && stored_q[j] < v) j++;
                stored_q.insert(j, v);
                r = '{ST_OK, POS_W'(j), v, COUNT_W'(n + 1)};
                n_ins_ok++;
            end
        end else if (int'(pos) >= n) begin
            r = '{ST_BADPOS, pos, '0, COUNT_W'(n)};
            n_badpos++;
        end else begin
            r = '{ST_OK, pos, stored_q[pos], COUNT_W'(n - 1)};
            stored_q.delete(int'(pos));
            n_del_ok++;
        end
        if (stored_q.size() > peak_count) peak_count = stored_q.size();
        return r;
    endfunction

    task automatic send_word(logic op, t_value v, logic [POS_W-1:0] pos);
        if (!quiet) begin
            while ($urandom_range(99) < 13) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, pos, v};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        expected_q.push_back(apply_request(op, v, pos));
    endtask

    task automatic insert_value(t_value v);
        send_word(REQ_INSERT, v, POS_W'($urandom_range(63)));
    endtask

    task automatic delete_at(logic [POS_W-1:0] pos);
        send_word(REQ_DELETE, t_value'($urandom), pos);
    endtask

    function automatic t_value pick_value();
        t_value v;
        case ($urandom_range(3))
            0: v = t_value'($urandom);
            1: v = t_value'($urandom_range(16)) - 8;
            2: v = (stored_q.size() > 0) ? stored_q[$urandom_range(stored_q.size() - 1)]
                                         : t_value'($urandom);
            default: begin
                case ($urandom_range(3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (stored_q.size() > 0 && $urandom_range(99) < 85)
            return POS_W'($urandom_range(stored_q.size() - 1));
        return POS_W'($urandom_range(63));
    endfunction

    task automatic test_empty_list();
        delete_at('0);
        delete_at(6'd63);
    endtask

    task automatic test_insert_order();
        insert_value(0);
        insert_value(32'sh7fff_ffff);
        insert_value(32'sh8000_0000);
        insert_value(-1);
        insert_value(1);
        insert_value(0);                // duplicate goes in front of the equal entry
        insert_value(32'sh7fff_ffff);
        insert_value(32'sh8000_0000);
    endtask

    task automatic test_delete_positions();
        delete_at(POS_W'(stored_q.size() - 1));
        delete_at('0);
        delete_at(POS_W'(stored_q.size() / 2));
        delete_at(POS_W'(stored_q.size()));   // one past the end
        delete_at(6'd63);
        insert_value(32'sh8000_0000);
        delete_at('0);
    endtask

    task automatic test_full_list();
        while (stored_q.size() < LIST_DEPTH) insert_value(pick_value());
        insert_value(32'sh7fff_ffff);
        insert_value(32'sh8000_0000);
        insert_value(pick_value());
        delete_at(6'd63);
        insert_value(32'sh7fff_ffff);
        delete_at(6'd63);
        delete_at('0);
        insert_value(pick_value());
        while (stored_q.size() > 20) delete_at(pick_position());
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (12) begin
            if ($urandom_range(1)) insert_value(pick_value());
            else delete_at(pick_position());
        end
        hold_request = 1'b0;
    endtask

    task automatic test_random();
        int insert_pct;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            quiet = (k >= 150 && k < 250);
            insert_pct = ((k / 100) % 2 == 0) ? 70 : 30;
            if (stored_q.size() == 0) insert_pct = 90;
            if ($urandom_range(99) < insert_pct) insert_value(pick_value());
            else delete_at(pick_position());
        end
        quiet = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request && !hold_seen) hold_left = HOLD_CYCLES;
        hold_seen = hold_request;
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: %h", o_m_tdata);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                n_checked++;
                if (o_m_tdata[1:0] !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_m_tdata[1:0]);
                    errors++;
                end
                if (o_m_tdata[7:2] !== exp_r.where) begin
                    $error("where: expected %0d, got %0d", exp_r.where, o_m_tdata[7:2]);
                    errors++;
                end
                if (o_m_tdata[39:8] !== exp_r.item_value) begin
                    $error("item_value: expected %0d, got %0d", exp_r.item_value,
                           $signed(o_m_tdata[39:8]));
                    errors++;
                end
                if (o_m_tdata[46:40] !== exp_r.count) begin
                    $error("count: expected %0d, got %0d", exp_r.count, o_m_tdata[46:40]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_insert_order();
        test_delete_positions();
        test_full_list();
        test_backpressure();
        test_random();
        i_s_tvalid <= 1'b0;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("covered %0d words (%0d checked): %0d inserts, %0d deletes, %0d full rejects,",
                 n_words, n_checked, n_ins_ok, n_del_ok, n_full);
        $display("%0d bad positions; list held up to %0d entries", n_badpos, peak_count);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
